FILE: rtl/tac_pkg.sv
// ---------------------------------------------------------------------------
// tac_pkg
// Shared types, codes and constants for the thermistor averaging and
// calibration block.
// ---------------------------------------------------------------------------
package tac_pkg;

  localparam int SAMPLES_AVERAGED_DEF = 16;
  localparam int ADC_BITS_DEF         = 12;

  localparam int SAMPLE_IN_W = 12;
  localparam int AVG_W       = 12;
  localparam int TEMP_W      = 24;
  localparam int STATUS_W    = 2;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int T24_MAX = 8388607;
  localparam int T24_MIN = -8388608;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_AVG_ZERO  = 2'd1,
    STATUS_ZERO_SPAN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_REF_LOW  = 2'd0,
    REG_REF_HIGH = 2'd1,
    REG_RAW_LOW  = 2'd2,
    REG_RAW_HIGH = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_DIV,
    ST_CHECK,
    ST_ROM,
    ST_PROD,
    ST_SETUP,
    ST_CAL_DIV,
    ST_FINAL,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic [TEMP_W-1:0] ref_low;
    logic [TEMP_W-1:0] ref_hi;
    logic [TEMP_W-1:0] raw_low;
    logic [TEMP_W-1:0] raw_hi;
  } cal_cfg_t;

  // Bits of the sample that are used: the port carries at most 12.
  function automatic int sample_width(input int adc_bits);
    return (adc_bits < SAMPLE_IN_W) ? adc_bits : SAMPLE_IN_W;
  endfunction

  function automatic int sum_width(input int n_avg, input int adc_bits);
    return sample_width(adc_bits) + $clog2(n_avg);
  endfunction

endpackage

FILE: rtl/tac_front.sv
// ---------------------------------------------------------------------------
// tac_front
// Accepts samples, accumulates each group and queues the finished sum.
// ---------------------------------------------------------------------------
module tac_front import tac_pkg::*; #(
  parameter int SAMPLES_AVERAGED = SAMPLES_AVERAGED_DEF,
  parameter int ADC_BITS         = ADC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_IN_W-1:0]     in_adc_sample,
  input  logic                       queue_full,
  output logic                       push,
  output logic [sum_width(SAMPLES_AVERAGED, ADC_BITS)-1:0] push_data
);

  localparam int SB    = sample_width(ADC_BITS);
  localparam int SUM_W = sum_width(SAMPLES_AVERAGED, ADC_BITS);
  localparam int CNT_W = (SAMPLES_AVERAGED > 1) ? $clog2(SAMPLES_AVERAGED) : 1;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] sum_add;
  logic             last;
  logic             accept;

  assign last     = (count_r == CNT_W'(SAMPLES_AVERAGED - 1));
  // Hold off only the sample that closes a group while the queue is full.
  assign in_stall = last && queue_full;
  assign accept   = in_valid && !in_stall;
  assign sum_add  = sum_r + SUM_W'(in_adc_sample[SB-1:0]);

  assign push      = accept && last;
  assign push_data = sum_add;

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (accept) begin
      if (last) begin
        count_nxt = '0;
        sum_nxt   = '0;
      end else begin
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

FILE: rtl/tac_fifo.sv
// ---------------------------------------------------------------------------
// tac_fifo
// Short queue of group sums between the front and back ends.
// ---------------------------------------------------------------------------
module tac_fifo import tac_pkg::*; #(
  parameter int WIDTH = 16,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/tac_rom.sv
// ---------------------------------------------------------------------------
// tac_rom
// Beta-equation temperature table, contents computed at elaboration,
// registered read.
// ---------------------------------------------------------------------------
module tac_rom import tac_pkg::*; #(
  parameter int ADDR_W   = 12,
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  output logic [TEMP_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  // 3977 / 298.15 in Q30, and 3977 * 2560 in Q30 as the dividend.
  localparam logic [63:0] KQ      = (64'd397700 << 30) / 64'd29815;
  localparam logic [63:0] NUM     = 64'd10181120 << 30;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  // log2 in Q30: integer part from the top bit, fraction by squaring.
  function automatic logic [63:0] log2_q30(input logic [31:0] x);
    logic [63:0] m;
    logic [63:0] frac;
    int          e;
    int          k;
    e = 0;
    for (k = 0; k < 31; k++) begin
      if ((x >> (k + 1)) != 0) begin
        e = k + 1;
      end
    end
    m    = 64'(x) << (30 - e);
    frac = '0;
    for (k = 0; k < 30; k++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(e) << 30) | frac;
  endfunction

  function automatic logic [TEMP_W-1:0] temp_entry(input int a, input int adc_bits);
    logic [63:0]        lp;
    logic [63:0]        ln;
    logic [63:0]        den_u;
    logic [63:0]        quo;
    logic [63:0]        rem;
    logic [63:0]        t;
    logic signed [63:0] lnq;
    logic signed [63:0] den;
    logic signed [63:0] tc;
    int                 k;
    if (a == 0) begin
      return '0;
    end
    lp = log2_q30(32'((1 << adc_bits) - a));
    ln = log2_q30(32'(a));
    if (lp >= ln) begin
      lnq = $signed(((lp - ln) * LN2_Q30) >> 30);
    end else begin
      lnq = -$signed(((ln - lp) * LN2_Q30) >> 30);
    end
    den = $signed(KQ) + lnq;
    if (den <= 0) begin
      return TEMP_W'(T24_MAX);
    end
    den_u = $unsigned(den);
    quo   = '0;
    rem   = '0;
    for (k = 63; k >= 0; k--) begin
      rem = {rem[62:0], NUM[k]};
      if (rem >= den_u) begin
        rem    = rem - den_u;
        quo[k] = 1'b1;
      end
    end
    t  = (quo + 64'd1) / 10;
    tc = $signed(t) - 64'sd69926;
    if (tc > T24_MAX) begin
      return TEMP_W'(T24_MAX);
    end
    if (tc < T24_MIN) begin
      return TEMP_W'(T24_MIN);
    end
    return tc[TEMP_W-1:0];
  endfunction

  logic [TEMP_W-1:0] rom_w [DEPTH];
  logic [TEMP_W-1:0] rd_data_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    localparam logic [TEMP_W-1:0] ENTRY = temp_entry(g, ADC_BITS);
    assign rom_w[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rom_w[addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/tac_back.sv
// ---------------------------------------------------------------------------
// tac_back
// Back end: average by reciprocal multiply, table lookup, two-point
// calibration through a radix-2 divider, and the output register.
// ---------------------------------------------------------------------------
module tac_back import tac_pkg::*; #(
  parameter int SAMPLES_AVERAGED = SAMPLES_AVERAGED_DEF,
  parameter int ADC_BITS         = ADC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       queue_empty,
  input  logic [sum_width(SAMPLES_AVERAGED, ADC_BITS)-1:0] queue_data,
  output logic                       queue_pop,
  input  cal_cfg_t                   cfg,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [AVG_W-1:0]           out_avg_count,
  output logic signed [TEMP_W-1:0]   out_raw_temp,
  output logic signed [TEMP_W-1:0]   out_cal_temp,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int SB        = sample_width(ADC_BITS);
  localparam int SUM_W     = sum_width(SAMPLES_AVERAGED, ADC_BITS);
  localparam int DIV_W     = 2 * TEMP_W;
  localparam int DVS_W     = TEMP_W;
  localparam int DIV_STEPS = DIV_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int DIFF_W    = TEMP_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CAL_W     = PROD_W;

  localparam int AVG_SHIFT  = SUM_W + $clog2(SAMPLES_AVERAGED);
  localparam int MUL_W      = SUM_W + 1;
  localparam int AVG_PROD_W = SUM_W + MUL_W;
  // Reciprocal of the group size, rounded up: exact for every group sum.
  localparam logic [MUL_W-1:0] AVG_MUL = MUL_W'(((64'd1 << AVG_SHIFT) +
    64'(SAMPLES_AVERAGED) - 64'd1) / 64'(SAMPLES_AVERAGED));

  back_state_t state_r, state_nxt;

  logic [DIV_W-1:0]         quo_r;
  logic [DVS_W-1:0]         rem_r;
  logic [DVS_W-1:0]         dvs_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic [SB-1:0]            avg_r;
  logic signed [DIFF_W-1:0] span_r;
  logic signed [DIFF_W-1:0] b_r;
  logic signed [DIFF_W-1:0] a_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     neg_r;
  logic [TEMP_W-1:0]        raw_r;
  logic [TEMP_W-1:0]        cal_r;
  status_t                  status_r;

  logic                     out_valid_r, out_valid_nxt;
  logic [AVG_W-1:0]         out_avg_r;
  logic [TEMP_W-1:0]        out_raw_r;
  logic [TEMP_W-1:0]        out_cal_r;
  status_t                  out_status_r;

  logic [DVS_W:0]           trial;
  logic                     trial_ge;
  logic [DVS_W-1:0]         rem_step;
  logic [DIV_W-1:0]         quo_step;
  logic                     div_last;
  logic                     div_run;
  logic                     out_free;
  logic                     out_load;
  logic [TEMP_W-1:0]        rom_data;
  logic [PROD_W-1:0]        prod_mag;
  logic [DIFF_W-1:0]        span_mag;
  logic signed [CAL_W-1:0]  ref_low_x;
  logic signed [CAL_W-1:0]  quo_x;
  logic signed [CAL_W-1:0]  cal_pre;
  logic [TEMP_W-1:0]        cal_sat;
  logic [AVG_PROD_W-1:0]    avg_prod;

  tac_rom #(
    .ADDR_W   (SB),
    .ADC_BITS (ADC_BITS)
  ) u_rom (
    .clk     (clk),
    .addr    (avg_r),
    .rd_data (rom_data)
  );

  // Group sum times the reciprocal; the average sits above AVG_SHIFT.
  assign avg_prod = AVG_PROD_W'(quo_r[SUM_W-1:0]) * AVG_PROD_W'(AVG_MUL);

  // One quotient bit per cycle, restoring.
  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, dvs_r});
  assign rem_step = trial_ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
  assign quo_step = {quo_r[DIV_W-2:0], trial_ge};
  assign div_last = (dcnt_r == DCNT_W'(DIV_STEPS - 1));

  assign prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign span_mag = span_r[DIFF_W-1] ? DIFF_W'(-span_r) : DIFF_W'(span_r);

  // Signed quotient folded into the offset add.
  assign ref_low_x = {{(CAL_W-TEMP_W){cfg.ref_low[TEMP_W-1]}}, cfg.ref_low};
  assign quo_x     = {{(CAL_W-DIV_W){1'b0}}, quo_r};
  assign cal_pre   = neg_r ? (ref_low_x - quo_x) : (ref_low_x + quo_x);

  always_comb begin
    if (cal_pre > T24_MAX) begin
      cal_sat = TEMP_W'(T24_MAX);
    end else if (cal_pre < T24_MIN) begin
      cal_sat = TEMP_W'(T24_MIN);
    end else begin
      cal_sat = cal_pre[TEMP_W-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!queue_empty) state_nxt = ST_AVG_DIV;
      end
      ST_AVG_DIV: state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = (avg_r == '0) ? ST_OUT : ST_ROM;
      end
      ST_ROM: begin
        state_nxt = (span_r == '0) ? ST_OUT : ST_PROD;
      end
      ST_PROD:  state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_CAL_DIV;
      ST_CAL_DIV: begin
        if (div_last) state_nxt = ST_FINAL;
      end
      ST_FINAL: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    queue_pop = 1'b0;
    div_run   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:    queue_pop = !queue_empty;
      ST_CAL_DIV: div_run   = 1'b1;
      ST_OUT:     out_load  = out_free;
      default: begin
        queue_pop = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (queue_pop) begin
      quo_r <= DIV_W'(queue_data);
    end
    if (div_run) begin
      quo_r  <= quo_step;
      rem_r  <= rem_step;
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (state_r == ST_AVG_DIV) begin
      avg_r <= avg_prod[AVG_SHIFT +: SB];
    end
    if (state_r == ST_CHECK) begin
      span_r   <= {cfg.raw_hi[TEMP_W-1], cfg.raw_hi} -
                  {cfg.raw_low[TEMP_W-1], cfg.raw_low};
      b_r      <= {cfg.ref_hi[TEMP_W-1], cfg.ref_hi} -
                  {cfg.ref_low[TEMP_W-1], cfg.ref_low};
      raw_r    <= '0;
      cal_r    <= '0;
      status_r <= (avg_r == '0) ? STATUS_AVG_ZERO : STATUS_OK;
    end
    if (state_r == ST_ROM) begin
      raw_r <= rom_data;
      a_r   <= {rom_data[TEMP_W-1], rom_data} - {cfg.raw_low[TEMP_W-1], cfg.raw_low};
      if (span_r == '0) begin
        status_r <= STATUS_ZERO_SPAN;
      end
    end
    if (state_r == ST_PROD) begin
      prod_r <= a_r * b_r;
    end
    if (state_r == ST_SETUP) begin
      quo_r  <= prod_mag[DIV_W-1:0];
      rem_r  <= '0;
      dvs_r  <= span_mag[DVS_W-1:0];
      neg_r  <= prod_r[PROD_W-1] ^ span_r[DIFF_W-1];
      dcnt_r <= '0;
    end
    if (state_r == ST_FINAL) begin
      cal_r <= cal_sat;
    end
    if (out_load) begin
      out_avg_r    <= AVG_W'(avg_r);
      out_raw_r    <= raw_r;
      out_cal_r    <= cal_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_avg_count = out_avg_r;
  assign out_raw_temp  = out_raw_r;
  assign out_cal_temp  = out_cal_r;
  assign out_status    = out_status_r;

  a_avg_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_AVG_ZERO) |->
      (out_raw_r == '0 && out_cal_r == '0))
    else $error("average-zero result carries nonzero temperatures");

  a_zero_span_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_ZERO_SPAN) |-> (out_cal_r == '0))
    else $error("zero-span result carries nonzero calibrated temperature");

  a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CAL_DIV) |-> (dcnt_r <= DCNT_W'(DIV_STEPS - 1)))
    else $error("divider step count ran past its end");

  a_pop_only_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    queue_pop |-> !queue_empty)
    else $error("pop from an empty queue");

endmodule

FILE: rtl/thermistor_average_and_calibrate.sv
// ---------------------------------------------------------------------------
// thermistor_average_and_calibrate
// Thermistor sample averager with beta-equation lookup and two-point
// calibration.
// ---------------------------------------------------------------------------
// Each accepted transaction on the in_ channel carries one ADC conversion.
// Every SAMPLES_AVERAGED samples the block emits one out_ transaction with
// the average, the beta-equation temperature (10k divider, B 3977, 1/256 C)
// and the two-point calibrated temperature; status flags an average of zero
// (open sensor, both temperatures zero) and a zero calibration span
// (calibrated temperature zero). The front end takes one sample per cycle
// and pushes each finished group sum into a two-entry queue; it stalls only
// when a group closes while that queue is full. The back end works on one
// group at a time (no lookup or divide when the average is zero, no divide
// on a zero span) and waits while the output is stalled: the average is a
// single multiply by the reciprocal of the group size, and the calibration
// quotient comes from a one-bit-per-cycle divider that runs 48 steps. The
// queue lets the front end keep taking samples while a group is worked on.
// Calibration registers sit at byte addresses 0, 4, 8 and 12 (reference
// low, reference high, raw low, raw high), 24-bit signed, read back
// sign-extended to 32 bits; write them only while no group is in flight.
// ---------------------------------------------------------------------------
module thermistor_average_and_calibrate import tac_pkg::*; #(
  parameter int SAMPLES_AVERAGED = SAMPLES_AVERAGED_DEF,
  parameter int ADC_BITS         = ADC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // sample channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_IN_W-1:0]   in_adc_sample,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [AVG_W-1:0]         out_avg_count,
  output logic signed [TEMP_W-1:0] out_raw_temp,
  output logic signed [TEMP_W-1:0] out_cal_temp,
  output logic [STATUS_W-1:0]      out_status,
  // calibration register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready
);

  localparam int SUM_W = sum_width(SAMPLES_AVERAGED, ADC_BITS);

  cal_cfg_t          cfg_r;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;
  logic [TEMP_W-1:0] rd_val;

  logic              queue_full;
  logic              queue_empty;
  logic              queue_push;
  logic              queue_pop;
  logic [SUM_W-1:0]  push_data;
  logic [SUM_W-1:0]  queue_data;

  // Register file: write on the access phase, decode by word address.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_REF_LOW:  cfg_r.ref_low <= pwdata[TEMP_W-1:0];
        REG_REF_HIGH: cfg_r.ref_hi  <= pwdata[TEMP_W-1:0];
        REG_RAW_LOW:  cfg_r.raw_low <= pwdata[TEMP_W-1:0];
        REG_RAW_HIGH: cfg_r.raw_hi  <= pwdata[TEMP_W-1:0];
        default:      cfg_r         <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_REF_LOW:  rd_val = cfg_r.ref_low;
      REG_REF_HIGH: rd_val = cfg_r.ref_hi;
      REG_RAW_LOW:  rd_val = cfg_r.raw_low;
      REG_RAW_HIGH: rd_val = cfg_r.raw_hi;
      default:      rd_val = '0;
    endcase
  end

  // Read back sign-extended.
  assign prdata = {{(CFG_DATA_W-TEMP_W){rd_val[TEMP_W-1]}}, rd_val};

  // Front end: accumulate and close groups.
  tac_front #(
    .SAMPLES_AVERAGED (SAMPLES_AVERAGED),
    .ADC_BITS         (ADC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_adc_sample (in_adc_sample),
    .queue_full    (queue_full),
    .push          (queue_push),
    .push_data     (push_data)
  );

  // Queue of finished group sums decouples the two ends.
  tac_fifo #(
    .WIDTH (SUM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (queue_push),
    .push_data (push_data),
    .pop       (queue_pop),
    .rd_data   (queue_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // Back end: divide, look up, calibrate, hold the result.
  tac_back #(
    .SAMPLES_AVERAGED (SAMPLES_AVERAGED),
    .ADC_BITS         (ADC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .queue_empty   (queue_empty),
    .queue_data    (queue_data),
    .queue_pop     (queue_pop),
    .cfg           (cfg_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_avg_count (out_avg_count),
    .out_raw_temp  (out_raw_temp),
    .out_cal_temp  (out_cal_temp),
    .out_status    (out_status)
  );

endmodule
